// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define SIC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked through reset.
`define SIC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/sic_pkg.sv
package sic_pkg;

    // Default structural sizes.
    localparam int HOLD_TIMER_WIDTH_DEF = 16;
    localparam int HISTORY_WIDTH_DEF    = 31;

    // Register field widths.
    localparam int DEB_LEN_W   = 5;
    localparam int HOLD_TIME_W = 16;

    // Register reset values.
    localparam logic [DEB_LEN_W-1:0]   DEB_LEN_RST   = 5'd6;
    localparam logic [HOLD_TIME_W-1:0] HOLD_TIME_RST = 16'd100;
    localparam logic                   HOLD_EN_RST   = 1'b1;

    // Configuration port geometry.
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Register indexes.
    localparam logic [1:0] REG_DEBOUNCE_LENGTH  = 2'd0;
    localparam logic [1:0] REG_HOLD_TIME_MS     = 2'd1;
    localparam logic [1:0] REG_HOLD_MODE_ENABLE = 2'd2;

    // Interlock machine modes.
    localparam logic [1:0] MODE_INTERLOCK = 2'd0;
    localparam logic [1:0] MODE_NORMAL    = 2'd1;
    localparam logic [1:0] MODE_HOLD      = 2'd2;

    // Debouncer channels: four switches and the reset button.
    localparam int NUM_DEB  = 5;
    localparam int DEB_RST  = 4;

    typedef struct packed {
        logic [DEB_LEN_W-1:0]   debounce_length;
        logic [HOLD_TIME_W-1:0] hold_time_ms;
        logic                   hold_mode_enable;
    } t_cfg;

    typedef struct packed {
        logic [3:0] switches;
        logic [7:0] comparators;
        logic       ack_level;
        logic       reset_pressed;
        logic       ms_tick;
    } t_in_item;

    typedef struct packed {
        logic       ccs_enable;
        logic       beam_enable;
        logic       hv_enable;
        logic       normal_operation;
        logic [7:0] status_flags;
        logic [7:0] fault_flags;
        logic       ack_echo;
    } t_out_item;

endpackage

// File: sv/sic_in_if.sv
interface sic_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] switches;
    logic [7:0] comparators;
    logic       ack_level;
    logic       reset_pressed;
    logic       ms_tick;

    modport source (
        output valid, switches, comparators, ack_level, reset_pressed, ms_tick,
        input  ready
    );

    modport sink (
        input  valid, switches, comparators, ack_level, reset_pressed, ms_tick,
        output ready
    );
endinterface

// File: sv/sic_out_if.sv
interface sic_out_if;
    logic       valid;
    logic       ready;
    logic       ccs_enable;
    logic       beam_enable;
    logic       hv_enable;
    logic       normal_operation;
    logic [7:0] status_flags;
    logic [7:0] fault_flags;
    logic       ack_echo;

    modport source (
        output valid, ccs_enable, beam_enable, hv_enable, normal_operation,
               status_flags, fault_flags, ack_echo,
        input  ready
    );

    modport sink (
        input  valid, ccs_enable, beam_enable, hv_enable, normal_operation,
               status_flags, fault_flags, ack_echo,
        output ready
    );
endinterface

// File: sv/sic_debounce.sv
module sic_debounce #(
    parameter int HISTORY_WIDTH = sic_pkg::HISTORY_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic [HISTORY_WIDTH-1:0] i_win,
    input  logic                     i_sample,
    output logic                     o_level
);

    logic [HISTORY_WIDTH-1:0] r_hist;
    logic [HISTORY_WIDTH-1:0] n_hist;
    logic                     r_stable;
    logic                     n_stable;
    logic [HISTORY_WIDTH-1:0] w_masked;

    // Shift the new sample in at the bottom of the history.
    generate
        if (HISTORY_WIDTH > 1) begin : g_shift
            assign n_hist = {r_hist[HISTORY_WIDTH-2:0], i_sample};
        end else begin : g_single
            assign n_hist = i_sample;
        end
    endgenerate

    // The level changes only when the whole window agrees.
    always_comb begin
        w_masked = n_hist & i_win;
        n_stable = r_stable;
        if (w_masked == '0) begin
            n_stable = 1'b0;
        end else if (w_masked == i_win) begin
            n_stable = 1'b1;
        end
    end

    assign o_level = n_stable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist   <= '0;
            r_stable <= 1'b0;
        end else if (i_step) begin
            r_hist   <= n_hist;
            r_stable <= n_stable;
        end
    end

endmodule

// File: sv/sic_cfg.sv
module sic_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sic_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [sic_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [sic_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    output sic_pkg::t_cfg                      o_cfg
);

    sic_pkg::t_cfg r_cfg;
    logic          w_wr;
    logic [1:0]    w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[3:2];
    assign o_cfg  = r_cfg;

    // Register writes on the access phase; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_length  <= sic_pkg::DEB_LEN_RST;
            r_cfg.hold_time_ms     <= sic_pkg::HOLD_TIME_RST;
            r_cfg.hold_mode_enable <= sic_pkg::HOLD_EN_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                sic_pkg::REG_DEBOUNCE_LENGTH: begin
                    r_cfg.debounce_length <= pwdata[sic_pkg::DEB_LEN_W-1:0];
                end
                sic_pkg::REG_HOLD_TIME_MS: begin
                    r_cfg.hold_time_ms <= pwdata[sic_pkg::HOLD_TIME_W-1:0];
                end
                sic_pkg::REG_HOLD_MODE_ENABLE: begin
                    r_cfg.hold_mode_enable <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read mux.
    always_comb begin
        unique case (w_idx)
            sic_pkg::REG_DEBOUNCE_LENGTH: begin
                prdata = sic_pkg::CFG_DATA_W'(r_cfg.debounce_length);
            end
            sic_pkg::REG_HOLD_TIME_MS: begin
                prdata = sic_pkg::CFG_DATA_W'(r_cfg.hold_time_ms);
            end
            sic_pkg::REG_HOLD_MODE_ENABLE: begin
                prdata = sic_pkg::CFG_DATA_W'(r_cfg.hold_mode_enable);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

// File: sv/sic_core.sv
module sic_core #(
    parameter int HOLD_TIMER_WIDTH = sic_pkg::HOLD_TIMER_WIDTH_DEF,
    parameter int HISTORY_WIDTH    = sic_pkg::HISTORY_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  sic_pkg::t_cfg       i_cfg,
    input  sic_pkg::t_in_item   i_item,
    output sic_pkg::t_out_item  o_result
);

    localparam int LW    = sic_pkg::DEB_LEN_W;
    localparam int CMP_W = (HOLD_TIMER_WIDTH > sic_pkg::HOLD_TIME_W) ?
                           HOLD_TIMER_WIDTH : sic_pkg::HOLD_TIME_W;

    logic [1:0]                  r_mode;
    logic [1:0]                  n_mode;
    logic                        r_reset_prev;
    logic                        r_ack_prev;
    logic                        r_ack_echo;
    logic                        n_ack_echo;
    logic [7:0]                  r_lat_faults;
    logic [7:0]                  n_lat_faults;
    logic [2:0]                  r_lat_sw;
    logic [2:0]                  n_lat_sw;
    logic                        r_lat_timer;
    logic                        n_lat_timer;
    logic [HOLD_TIMER_WIDTH-1:0] r_hold_cnt;
    logic [HOLD_TIMER_WIDTH-1:0] n_hold_cnt;
    logic [HOLD_TIMER_WIDTH-1:0] w_cnt_inc;

    logic [LW-1:0]               w_len;
    logic [HISTORY_WIDTH-1:0]    w_win;
    logic [sic_pkg::NUM_DEB-1:0] w_samples;
    logic [sic_pkg::NUM_DEB-1:0] w_levels;
    logic                        w_ack_chg;
    logic                        w_edge;
    logic                        w_s3k;
    logic                        w_sbeam;
    logic                        w_sccs;
    logic                        w_s80k;
    logic                        w_comp_any;
    logic                        w_ccs;
    logic                        w_beam;
    logic                        w_hv;
    logic                        w_nom;

    // Effective window length, clamped to 1..HISTORY_WIDTH.
    always_comb begin
        if (i_cfg.debounce_length == '0) begin
            w_len = LW'(1);
        end else if (i_cfg.debounce_length > LW'(HISTORY_WIDTH)) begin
            w_len = LW'(HISTORY_WIDTH);
        end else begin
            w_len = i_cfg.debounce_length;
        end
        for (int i = 0; i < HISTORY_WIDTH; i++) begin
            w_win[i] = (LW'(i) < w_len);
        end
    end

    // One debouncer per switch and one for the reset button.
    assign w_samples = {i_item.reset_pressed, i_item.switches};

    generate
        for (genvar g = 0; g < sic_pkg::NUM_DEB; g++) begin : g_deb
            sic_debounce #(
                .HISTORY_WIDTH (HISTORY_WIDTH)
            ) u_deb (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_step   (i_step),
                .i_win    (w_win),
                .i_sample (w_samples[g]),
                .o_level  (w_levels[g])
            );
        end
    endgenerate

    assign w_s3k      = w_levels[0];
    assign w_sbeam    = w_levels[1];
    assign w_sccs     = w_levels[2];
    assign w_s80k     = w_levels[3];
    assign w_edge     = w_levels[sic_pkg::DEB_RST] & ~r_reset_prev;
    assign w_ack_chg  = i_item.ack_level ^ r_ack_prev;
    assign w_comp_any = |i_item.comparators;

    // Saturating tick count used while holding.
    assign w_cnt_inc = (i_item.ms_tick && (r_hold_cnt != '1)) ?
                       r_hold_cnt + HOLD_TIMER_WIDTH'(1) : r_hold_cnt;

    // Mode transition and latches.
    always_comb begin
        n_mode      = sic_pkg::MODE_INTERLOCK;
        n_hold_cnt  = r_hold_cnt;
        n_ack_echo  = r_ack_echo ^ w_ack_chg;
        n_lat_timer = w_ack_chg ? 1'b0 : r_lat_timer;
        unique case (r_mode)
            sic_pkg::MODE_NORMAL: begin
                if (i_cfg.hold_mode_enable && (i_item.comparators[1:0] != 2'b00)) begin
                    n_mode      = sic_pkg::MODE_HOLD;
                    n_hold_cnt  = '0;
                    n_lat_timer = 1'b1;
                end else if (w_comp_any || !w_s80k || !w_s3k) begin
                    n_mode = sic_pkg::MODE_INTERLOCK;
                end else begin
                    n_mode = sic_pkg::MODE_NORMAL;
                end
            end
            sic_pkg::MODE_HOLD: begin
                n_hold_cnt = w_cnt_inc;
                if (!i_item.comparators[0] &&
                    (CMP_W'(w_cnt_inc) >= CMP_W'(i_cfg.hold_time_ms))) begin
                    n_mode = sic_pkg::MODE_INTERLOCK;
                end else begin
                    n_mode = sic_pkg::MODE_HOLD;
                end
            end
            default: begin
                if (i_cfg.hold_mode_enable && i_item.comparators[0]) begin
                    n_mode      = sic_pkg::MODE_HOLD;
                    n_hold_cnt  = '0;
                    n_lat_timer = 1'b1;
                end else if (w_edge && !w_comp_any && w_s80k && w_s3k) begin
                    n_mode = sic_pkg::MODE_NORMAL;
                end else begin
                    n_mode = sic_pkg::MODE_INTERLOCK;
                end
            end
        endcase
        n_lat_faults = (w_ack_chg ? 8'h00 : r_lat_faults) | i_item.comparators;
        n_lat_sw     = (w_ack_chg ? 3'b000 : r_lat_sw) | {w_s80k, w_sccs, w_sbeam};
    end

    // Enables follow the mode reached in this step.
    always_comb begin
        w_ccs  = 1'b0;
        w_beam = 1'b0;
        w_hv   = 1'b0;
        w_nom  = 1'b0;
        unique case (n_mode)
            sic_pkg::MODE_NORMAL: begin
                w_ccs  = w_sccs;
                w_beam = w_sbeam;
                w_hv   = w_s3k;
                w_nom  = 1'b1;
            end
            sic_pkg::MODE_HOLD: begin
            end
            default: begin
                w_hv = w_s3k;
            end
        endcase
    end

    always_comb begin
        o_result.ccs_enable       = w_ccs;
        o_result.beam_enable      = w_beam;
        o_result.hv_enable        = w_hv;
        o_result.normal_operation = w_nom;
        o_result.status_flags     = {n_lat_sw, n_lat_timer, w_nom, w_hv, w_beam, w_ccs};
        o_result.fault_flags      = n_lat_faults;
        o_result.ack_echo         = n_ack_echo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= sic_pkg::MODE_INTERLOCK;
            r_reset_prev <= 1'b0;
            r_ack_prev   <= 1'b0;
            r_ack_echo   <= 1'b0;
            r_lat_faults <= '0;
            r_lat_sw     <= '0;
            r_lat_timer  <= 1'b0;
            r_hold_cnt   <= '0;
        end else if (i_step) begin
            r_mode       <= n_mode;
            r_reset_prev <= w_levels[sic_pkg::DEB_RST];
            r_ack_prev   <= i_item.ack_level;
            r_ack_echo   <= n_ack_echo;
            r_lat_faults <= n_lat_faults;
            r_lat_sw     <= n_lat_sw;
            r_lat_timer  <= n_lat_timer;
            r_hold_cnt   <= n_hold_cnt;
        end
    end

endmodule

// File: sv/safety_interlock_controller_unit.sv
// Safety interlock controller.
// Input channel i_in carries one sampling step per transaction: four raw
// switches, eight comparator fault bits, the acknowledge level, the reset
// button and a millisecond tick. Output channel o_out returns exactly one
// result transaction per input transaction, in order: the ccs, beam and 3kV
// enables, the normal operation flag, status and latched fault flags, and the
// acknowledge echo. Both channels use a valid/ready handshake.
// A transaction is captured in an input register and then evaluated into an
// output register, which offers its result. One transaction per cycle is
// sustained while the receiver does not stall; the combinational evaluation
// of the mode machine and debouncers between the two registers sets that figure.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more transaction; ready then drops until
// the output is taken.
// The APB port writes debounce length, hold time and hold enable; the user is
// to write it only while the block is idle, which the block does not enforce.
// A synchronous active-low reset empties both registers, returns to interlock
// mode, clears debounce histories and latches, and restores the register defaults.
module safety_interlock_controller_unit #(
    parameter int HOLD_TIMER_WIDTH = sic_pkg::HOLD_TIMER_WIDTH_DEF,
    parameter int HISTORY_WIDTH    = sic_pkg::HISTORY_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sic_in_if.sink                         i_in,
    sic_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sic_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sic_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sic_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    sic_pkg::t_cfg      w_cfg;
    sic_pkg::t_in_item  w_in_item;
    sic_pkg::t_in_item  r_in_item;
    sic_pkg::t_out_item w_result;
    sic_pkg::t_out_item r_out_item;
    logic               r_in_valid;
    logic               r_out_valid;
    logic               w_load;
    logic               w_in_ready;

    sic_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Input stage: take a transaction when empty or when it moves on.
    assign w_load     = r_in_valid & (~r_out_valid | o_out.ready);
    assign w_in_ready = ~r_in_valid | w_load;
    assign i_in.ready = w_in_ready;

    always_comb begin
        w_in_item.switches      = i_in.switches;
        w_in_item.comparators   = i_in.comparators;
        w_in_item.ack_level     = i_in.ack_level;
        w_in_item.reset_pressed = i_in.reset_pressed;
        w_in_item.ms_tick       = i_in.ms_tick;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_in_item <= w_in_item;
        end
    end

    sic_core #(
        .HOLD_TIMER_WIDTH (HOLD_TIMER_WIDTH),
        .HISTORY_WIDTH    (HISTORY_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_load),
        .i_cfg    (w_cfg),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    // Output stage: result register held until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_item <= w_result;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.ccs_enable       = r_out_item.ccs_enable;
    assign o_out.beam_enable      = r_out_item.beam_enable;
    assign o_out.hv_enable        = r_out_item.hv_enable;
    assign o_out.normal_operation = r_out_item.normal_operation;
    assign o_out.status_flags     = r_out_item.status_flags;
    assign o_out.fault_flags      = r_out_item.fault_flags;
    assign o_out.ack_echo         = r_out_item.ack_echo;

endmodule

// File: sv/sic_checker.sv
`include "assert_macros.svh"

module sic_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    // A pending result stays offered until it is taken.
    `SIC_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid, "result dropped while stalled")

    // Reset empties the output register.
    `SIC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // With nothing waiting at the output, the input side is always open.
    `SIC_ASSERT(a_in_open, i_clk, i_rst_n, !i_out_valid |-> i_in_ready, "input blocked with empty output")

    // An accepted transaction reaches the output register unless the receiver stalls.
    `SIC_ASSERT(a_latency, i_clk, i_rst_n, (i_in_valid && i_in_ready) ##1 i_out_ready |=> i_out_valid, "result missing after accepted transaction")

endmodule

bind safety_interlock_controller_unit sic_checker u_sic_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);
